FILE: rtl/xrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrc_pkg: shared types and constants of the crosspoint route commander
// Transfer payloads, result kinds, register indexes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package xrc_pkg;

  // Default limits of the installation
  localparam int MAX_OUTPUTS_DEFAULT = 16;
  localparam int MAX_INPUTS_DEFAULT  = 128;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 1'd1;

  localparam logic [7:0] INPUT_COUNT_RESET  = 8'd8;
  localparam logic [4:0] OUTPUT_COUNT_RESET = 5'd8;

  // Up to this many sources a board holds 8 sources, above it 16
  localparam logic [7:0] SMALL_BOARD_LIMIT = 8'd8;

  typedef enum logic [1:0] {
    KIND_DISCONNECT = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DONE       = 2'd2,
    KIND_REJECTED   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       plane;
    logic [7:0] source;
    logic [4:0] dest;
  } req_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       plane_out;
    logic [2:0] board;
    logic [7:0] command_byte;
    logic       last;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_req;
    logic  start_sweep;
    logic  advance;
    logic  write_route;
    logic  emit;
    kind_t emit_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;
    logic empty_sweep;
    logic need_disc;
    logic need_conn;
    logic at_stop;
    logic slot_free;
  } status_t;

endpackage

FILE: rtl/xrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrc_datapath: route tables, request and sweep registers, result register
// Holds configuration, both route tables and the output register; forms the
// board address and command byte of each result.
// ----------------------------------------------------------------------------
module xrc_datapath #(
  parameter int MAX_OUTPUTS = xrc_pkg::MAX_OUTPUTS_DEFAULT,
  parameter int MAX_INPUTS  = xrc_pkg::MAX_INPUTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  xrc_pkg::req_item_t             req_item,
  input  logic                           cfg_we,
  input  logic [xrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  xrc_pkg::cmd_t                  cmd,
  output xrc_pkg::status_t               status,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output xrc_pkg::rsp_item_t             rsp_item
);

  localparam int OUT_IDX_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int SRC_IDX_W = $clog2(MAX_INPUTS);

  logic [7:0]           input_count;
  logic [4:0]           output_count;
  logic                 req_plane;
  logic [7:0]           req_source;
  logic [4:0]           req_dest;
  logic [OUT_IDX_W-1:0] cur_out;
  logic [OUT_IDX_W-1:0] stop_out;

  logic                 route_valid [2][MAX_OUTPUTS];
  logic [SRC_IDX_W-1:0] route_src   [2][MAX_OUTPUTS];

  logic [7:0]           nin;
  logic [4:0]           nout;
  logic                 wide_board;
  logic                 entry_valid;
  logic [6:0]           entry_idx;
  logic [6:0]           conn_idx;
  logic [OUT_IDX_W-1:0] first_out;
  logic [OUT_IDX_W-1:0] last_out;
  xrc_pkg::rsp_item_t   rsp_next;

  function automatic xrc_pkg::rsp_item_t build_cmd(
    input xrc_pkg::kind_t       kind,
    input logic                 plane,
    input logic [6:0]           idx,
    input logic [OUT_IDX_W-1:0] out_idx,
    input logic                 wide
  );
    xrc_pkg::rsp_item_t item;
    logic [3:0]         low;
    item.kind      = kind;
    item.plane_out = plane;
    item.board     = wide ? idx[6:4] : idx[5:3];
    low            = wide ? idx[3:0] : {1'b0, idx[2:0]};
    item.command_byte = {low, 4'(out_idx)};
    item.last      = 1'b0;
    return item;
  endfunction

  // Effective counts, capped at the installed limits
  assign nin  = (input_count > 8'(MAX_INPUTS)) ? 8'(MAX_INPUTS) : input_count;
  assign nout = (output_count > 5'(MAX_OUTPUTS)) ? 5'(MAX_OUTPUTS) : output_count;
  assign wide_board = input_count > xrc_pkg::SMALL_BOARD_LIMIT;

  assign entry_valid = route_valid[req_plane][cur_out];
  assign entry_idx   = 7'(route_src[req_plane][cur_out]);
  assign conn_idx    = 7'(req_source - 8'd1);

  assign first_out = (req_dest == 5'd0) ? '0 : OUT_IDX_W'(req_dest - 5'd1);
  assign last_out  = (req_dest == 5'd0) ? OUT_IDX_W'(nout - 5'd1)
                                        : OUT_IDX_W'(req_dest - 5'd1);

  always_comb begin
    status.reject      = (req_source > nin) || (req_dest > nout);
    status.empty_sweep = (req_dest == 5'd0) && (nout == 5'd0);
    status.need_disc   = entry_valid && ((8'(entry_idx) + 8'd1) != req_source);
    status.need_conn   = req_source != 8'd0;
    status.at_stop     = cur_out == stop_out;
    status.slot_free   = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    case (cmd.emit_kind)
      xrc_pkg::KIND_DISCONNECT: begin
        rsp_next = build_cmd(xrc_pkg::KIND_DISCONNECT, req_plane, entry_idx, cur_out,
                             wide_board);
      end
      xrc_pkg::KIND_CONNECT: begin
        rsp_next = build_cmd(xrc_pkg::KIND_CONNECT, req_plane, conn_idx, cur_out,
                             wide_board);
      end
      default: begin
        rsp_next.kind         = cmd.emit_kind;
        rsp_next.plane_out    = req_plane;
        rsp_next.board        = 3'd0;
        rsp_next.command_byte = 8'd0;
        rsp_next.last         = 1'b1;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= xrc_pkg::INPUT_COUNT_RESET;
      output_count <= xrc_pkg::OUTPUT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xrc_pkg::REG_INPUT_COUNT:  input_count  <= cfg_data;
        xrc_pkg::REG_OUTPUT_COUNT: output_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Request and sweep registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_plane  <= req_item.plane;
      req_source <= req_item.source;
      req_dest   <= req_item.dest;
    end
    if (cmd.start_sweep) begin
      cur_out  <= first_out;
      stop_out <= last_out;
    end else if (cmd.advance) begin
      cur_out <= cur_out + 1'b1;
    end
  end

  // Route table: valid bits clear at reset, source indexes need none
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 2; p++) begin
        for (int o = 0; o < MAX_OUTPUTS; o++) begin
          route_valid[p][o] <= 1'b0;
        end
      end
    end else if (cmd.write_route) begin
      route_valid[req_plane][cur_out] <= status.need_conn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_route && status.need_conn) begin
      route_src[req_plane][cur_out] <= conn_idx[SRC_IDX_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

FILE: rtl/xrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrc_ctrl: request sequencer
// Checks a request, walks the outputs it touches and issues, for each, any
// needed disconnect and connect, then the closing result.
// ----------------------------------------------------------------------------
module xrc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  xrc_pkg::status_t status,
  output xrc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DISC,
    S_CONN,
    S_CLOSE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    cmd.load_req    = 1'b0;
    cmd.start_sweep = 1'b0;
    cmd.advance     = 1'b0;
    cmd.write_route = 1'b0;
    cmd.emit        = 1'b0;
    cmd.emit_kind   = xrc_pkg::KIND_DONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.reject || status.empty_sweep) begin
          state_next = S_CLOSE;
        end else begin
          cmd.start_sweep = 1'b1;
          state_next      = S_DISC;
        end
      end
      S_DISC: begin
        cmd.emit_kind = xrc_pkg::KIND_DISCONNECT;
        if (!status.need_disc) begin
          state_next = S_CONN;
        end else if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CONN;
        end
      end
      S_CONN: begin
        cmd.emit_kind = xrc_pkg::KIND_CONNECT;
        if (!status.need_conn || status.slot_free) begin
          cmd.emit        = status.need_conn;
          cmd.write_route = 1'b1;
          if (status.at_stop) begin
            state_next = S_CLOSE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_DISC;
          end
        end
      end
      S_CLOSE: begin
        cmd.emit_kind = status.reject ? xrc_pkg::KIND_REJECTED : xrc_pkg::KIND_DONE;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/crosspoint_route_commander_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crosspoint_route_commander_core: route table keeper for video and audio
// Turns route requests into disconnect and connect commands for the
// crosspoint boards and keeps one route table per plane.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_item): one transfer carries a
//   plane, a source (0 disconnects) and an output (0 sweeps every configured
//   output). req_stall is high from the transfer until the closing result of
//   that request has been loaded, so one request is in work at a time.
//   Result channel (rsp_valid / rsp_stall / rsp_item): per output touched, an
//   optional disconnect then an optional connect, then done or rejected with
//   last set. Results leave from one output register.
//   Sequence: after the check, the sequencer spends a disconnect step and a
//   connect step on every output touched, whether or not it sends a
//   command, then loads the closing result (a rejected or empty request goes
//   straight from the check to the close); the next request is taken the
//   cycle after that.
//   When the receiver stalls, the result register holds and the sequencer
//   waits in place before each further result; nothing is dropped.
//   Reset (rst, synchronous) clears every route, returns both counts to 8
//   and empties the result register. Configuration writes (cfg_we) land at
//   once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module crosspoint_route_commander_core #(
  parameter int MAX_OUTPUTS = xrc_pkg::MAX_OUTPUTS_DEFAULT,
  parameter int MAX_INPUTS  = xrc_pkg::MAX_INPUTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  xrc_pkg::req_item_t              req_item,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output xrc_pkg::rsp_item_t              rsp_item,
  input  logic                            cfg_we,
  input  logic [xrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  xrc_pkg::cmd_t    cmd;
  xrc_pkg::status_t status;

  // Sequencer: accept, check, walk the outputs, close
  xrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Tables, counters and the result register
  xrc_datapath #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .MAX_INPUTS  (MAX_INPUTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result loaded over a stalled result");

  // An accepted request holds off the next one
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in work");

  // Connect only for a nonzero source
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_kind == xrc_pkg::KIND_CONNECT) |-> status.need_conn)
    else $error("connect issued for a disconnect request");

  // A rejected request never touches the table
  assert property (@(posedge clk) disable iff (rst)
    cmd.write_route |-> !status.reject)
    else $error("route table written for a rejected request");

endmodule

FILE: dv/crosspoint_route_commander_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crosspoint_route_commander_core_test: self-checking bench of the route commander
// Drives a typed table of directed requests and then random requests under
// several source and output counts. Both channels idle at random but in one
// quiet phase; the result side holds off once for a long stretch. Results
// are compared with a directed row's typed results where it has them, else
// with the command list that a local copy of the route tables gives.
// ----------------------------------------------------------------------------
module crosspoint_route_commander_core_test;

  localparam int IN_LIMIT      = xrc_pkg::MAX_INPUTS_DEFAULT;
  localparam int OUT_LIMIT     = xrc_pkg::MAX_OUTPUTS_DEFAULT;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AFTER    = 65;   // request count that starts the long hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int N_PHASES      = 8;
  localparam int QUIET_PHASE   = 2;    // no idling on either side in this phase

  // One directed row: the request and, where it reads off at a glance, its results
  typedef struct packed {
    xrc_pkg::req_item_t req;
    logic [1:0]         n_typed;
    xrc_pkg::rsp_item_t first_result;
    xrc_pkg::rsp_item_t second_result;
  } route_case_t;

  localparam xrc_pkg::rsp_item_t NONE_R  = '0;
  localparam xrc_pkg::rsp_item_t DONE_V  = '{xrc_pkg::KIND_DONE, 1'b0, 3'd0, 8'h00, 1'b1};
  localparam xrc_pkg::rsp_item_t DONE_A  = '{xrc_pkg::KIND_DONE, 1'b1, 3'd0, 8'h00, 1'b1};
  localparam xrc_pkg::rsp_item_t REJ_V   =
    '{xrc_pkg::KIND_REJECTED, 1'b0, 3'd0, 8'h00, 1'b1};
  localparam xrc_pkg::rsp_item_t REJ_A   =
    '{xrc_pkg::KIND_REJECTED, 1'b1, 3'd0, 8'h00, 1'b1};
  localparam xrc_pkg::rsp_item_t CONN_V0 =
    '{xrc_pkg::KIND_CONNECT, 1'b0, 3'd0, 8'h00, 1'b0};
  localparam xrc_pkg::rsp_item_t CONN_A8 =
    '{xrc_pkg::KIND_CONNECT, 1'b1, 3'd0, 8'h77, 1'b0};

  localparam int N_DIRECTED = 22;
  // Reset counts hold here: 8 sources, 8 outputs, 8 sources per board
  localparam route_case_t DIRECTED [N_DIRECTED] = '{
    '{'{1'b0, 8'd1,   5'd1},  2'd2, CONN_V0, DONE_V},   // first route on empty table
    '{'{1'b1, 8'd8,   5'd8},  2'd2, CONN_A8, DONE_A},   // top source to top output
    '{'{1'b0, 8'd9,   5'd1},  2'd1, REJ_V,   NONE_R},   // source above count
    '{'{1'b1, 8'd0,   5'd9},  2'd1, REJ_A,   NONE_R},   // output above count
    '{'{1'b1, 8'd255, 5'd31}, 2'd1, REJ_A,   NONE_R},   // both fields at full scale
    '{'{1'b0, 8'd1,   5'd1},  2'd2, CONN_V0, DONE_V},   // same source: connect again only
    '{'{1'b0, 8'd2,   5'd1},  2'd0, NONE_R,  NONE_R},   // reroute: disconnect then connect
    '{'{1'b0, 8'd0,   5'd1},  2'd0, NONE_R,  NONE_R},   // disconnect a routed output
    '{'{1'b0, 8'd0,   5'd1},  2'd1, DONE_V,  NONE_R},   // disconnect an unrouted output
    '{'{1'b0, 8'd5,   5'd0},  2'd0, NONE_R,  NONE_R},   // broadcast connect
    '{'{1'b0, 8'd5,   5'd0},  2'd0, NONE_R,  NONE_R},   // broadcast of the same source
    '{'{1'b0, 8'd3,   5'd0},  2'd0, NONE_R,  NONE_R},   // broadcast reroute
    '{'{1'b1, 8'd0,   5'd0},  2'd0, NONE_R,  NONE_R},   // broadcast disconnect, one routed
    '{'{1'b1, 8'd0,   5'd0},  2'd1, DONE_A,  NONE_R},   // broadcast disconnect, none routed
    '{'{1'b0, 8'd8,   5'd8},  2'd0, NONE_R,  NONE_R},
    '{'{1'b1, 8'd4,   5'd3},  2'd0, NONE_R,  NONE_R},
    '{'{1'b0, 8'd0,   5'd0},  2'd0, NONE_R,  NONE_R},
    '{'{1'b1, 8'd8,   5'd0},  2'd0, NONE_R,  NONE_R},
    '{'{1'b0, 8'd1,   5'd8},  2'd0, NONE_R,  NONE_R},
    '{'{1'b1, 8'd0,   5'd8},  2'd0, NONE_R,  NONE_R},
    '{'{1'b0, 8'd128, 5'd16}, 2'd1, REJ_V,   NONE_R},   // top bits of both fields
    '{'{1'b1, 8'd0,   5'd16}, 2'd1, REJ_A,   NONE_R}
  };

  // Count settings per random phase; wide phases 0 and 2 are followed by a
  // narrow one so stale entries with large source indexes get torn down
  localparam logic [7:0] PHASE_INPUTS  [N_PHASES] = '{8'd128, 8'd8, 8'd255, 8'd0,
                                                     8'd1, 8'd9, 8'd16, 8'd128};
  localparam logic [4:0] PHASE_OUTPUTS [N_PHASES] = '{5'd16, 5'd16, 5'd31, 5'd0,
                                                     5'd1, 5'd5, 5'd16, 5'd16};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  xrc_pkg::req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  xrc_pkg::rsp_item_t rsp_item;
  logic cfg_we = 1'b0;
  logic [xrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [xrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Directed row on offer, -1 while random requests are offered
  int offer_row = -1;

  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;

  // Local copy of the block's state
  logic [7:0] route_mirror [32];
  logic [7:0] inputs_setting = xrc_pkg::INPUT_COUNT_RESET;
  logic [4:0] outputs_setting = xrc_pkg::OUTPUT_COUNT_RESET;

  xrc_pkg::rsp_item_t sweep_cmds [$];          // results of the request just planned
  xrc_pkg::rsp_item_t board_commands_due [$];  // results still to arrive, oldest first
  xrc_pkg::rsp_item_t want;

  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned broadcasts_taken = 0;
  int unsigned results_seen = 0;
  int unsigned kind_seen [4] = '{0, 0, 0, 0};

  crosspoint_route_commander_core #(
    .MAX_OUTPUTS(OUT_LIMIT),
    .MAX_INPUTS (IN_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item (req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item (rsp_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 32; i++) route_mirror[i] = 8'h00;
  end

  function automatic string show(input xrc_pkg::rsp_item_t r);
    return $sformatf("kind %0d plane %0d board %0d byte %02h last %0d",
                     r.kind, r.plane_out, r.board, r.command_byte, r.last);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Board command for source index idx on output outno (1-based)
  function automatic xrc_pkg::rsp_item_t board_command(input xrc_pkg::kind_t k,
                                                       input logic plane,
                                                       input int unsigned idx,
                                                       input int unsigned outno,
                                                       input int unsigned shift);
    xrc_pkg::rsp_item_t c;
    c.kind         = k;
    c.plane_out    = plane;
    c.board        = 3'((idx >> shift) & 7);
    c.command_byte = 8'((((idx & ((1 << shift) - 1)) << 4) | ((outno - 1) & 15)));
    c.last         = 1'b0;
    return c;
  endfunction

  function automatic xrc_pkg::rsp_item_t closing_result(input xrc_pkg::kind_t k,
                                                        input logic plane);
    xrc_pkg::rsp_item_t c;
    c = '0;
    c.kind      = k;
    c.plane_out = plane;
    c.last      = 1'b1;
    return c;
  endfunction

  // Work out the commands of one request and update the route copy.
  // Disconnect the old source unless it is the requested one, connect the new
  // one if any, then close with done; out-of-range requests reject outright.
  function automatic void plan_route_commands(input xrc_pkg::req_item_t r);
    int unsigned n_in, n_out, shift, first, stop, outno;
    logic [4:0] slot;
    logic [7:0] entry;
    sweep_cmds.delete();
    n_in  = (inputs_setting > IN_LIMIT) ? IN_LIMIT : inputs_setting;
    n_out = (outputs_setting > OUT_LIMIT) ? OUT_LIMIT : outputs_setting;
    shift = (inputs_setting <= xrc_pkg::SMALL_BOARD_LIMIT) ? 3 : 4;
    if (r.source > n_in || r.dest > n_out) begin
      sweep_cmds.push_back(closing_result(xrc_pkg::KIND_REJECTED, r.plane));
      return;
    end
    first = (r.dest == 0) ? 1 : r.dest;
    stop  = (r.dest == 0) ? n_out : r.dest;
    for (outno = first; outno <= stop; outno++) begin
      slot  = {r.plane, 4'(outno - 1)};
      entry = route_mirror[slot];
      if (entry[7] && int'(entry[6:0]) + 1 != int'(r.source))
        sweep_cmds.push_back(board_command(xrc_pkg::KIND_DISCONNECT, r.plane, entry[6:0],
                                           outno, shift));
      if (r.source != 0) begin
        sweep_cmds.push_back(board_command(xrc_pkg::KIND_CONNECT, r.plane,
                                           int'(r.source) - 1, outno, shift));
        route_mirror[slot] = {1'b1, 7'(r.source - 8'd1)};
      end else begin
        route_mirror[slot] = {1'b0, entry[6:0]};
      end
    end
    sweep_cmds.push_back(closing_result(xrc_pkg::KIND_DONE, r.plane));
  endfunction

  // Mostly in-range requests over a small source set so that reroutes and
  // repeats of the same source are common; a few are plain noise
  function automatic xrc_pkg::req_item_t random_request();
    xrc_pkg::req_item_t r;
    int unsigned n_in, n_out, pick;
    n_in  = (inputs_setting > IN_LIMIT) ? IN_LIMIT : inputs_setting;
    n_out = (outputs_setting > OUT_LIMIT) ? OUT_LIMIT : outputs_setting;
    r.plane = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 8)       r.source = 8'($urandom_range(0, 255));
    else if (pick < 20) r.source = 8'(n_in);
    else if (pick < 30) r.source = 8'd0;
    else                r.source = 8'($urandom_range(0, n_in));
    pick = $urandom_range(0, 99);
    if (pick < 6)       r.dest = 5'($urandom_range(0, 31));
    else if (pick < 26) r.dest = 5'd0;
    else                r.dest = 5'($urandom_range((n_out == 0) ? 0 : 1, n_out));
    return r;
  endfunction

  // Offer one request and hold it until the transfer; idle first at random
  task automatic send_request(input xrc_pkg::req_item_t r, input int row);
    while (sender_gaps && $urandom_range(0, 99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= r;
    offer_row <= row;
    do @(posedge clk); while (req_stall !== 1'b0);
  endtask

  // Drop valid and wait until every result of the phase has come back
  task automatic drain();
    req_valid <= 1'b0;
    offer_row <= -1;
    do @(negedge clk); while (board_commands_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the input count, then the output count, while the block is idle
  task automatic write_counts(input logic [7:0] n_in, input logic [4:0] n_out);
    cfg_we    <= 1'b1;
    cfg_index <= xrc_pkg::REG_INPUT_COUNT;
    cfg_data  <= n_in;
    @(posedge clk);
    cfg_index <= xrc_pkg::REG_OUTPUT_COUNT;
    cfg_data  <= {3'b000, n_out};
    @(posedge clk);
    cfg_we <= 1'b0;
    inputs_setting  = n_in;
    outputs_setting = n_out;
  endtask

  // Result side: random stalls, plus one long hold-off once enough requests
  // have gone in, so the block fills and stalls the request side
  initial begin : result_receiver
    int unsigned seen;
    bit held;
    seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (req_valid && req_stall === 1'b0) seen++;
      if (!held && seen == HOLD_AFTER) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= receiver_gaps && ($urandom_range(0, 99) < 22);
    end
  end

  // Check each result transfer against the oldest pending one, then plan
  // the results of any request transfer on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        results_seen++;
        if (board_commands_due.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with none pending: %s",
                                  results_seen, show(rsp_item)));
        end else begin
          want = board_commands_due.pop_front();
          if (rsp_item.kind !== want.kind || rsp_item.plane_out !== want.plane_out ||
              rsp_item.board !== want.board ||
              rsp_item.command_byte !== want.command_byte ||
              rsp_item.last !== want.last)
            note_mismatch($sformatf("result %0d: expected %s, got %s",
                                    results_seen, show(want), show(rsp_item)));
          kind_seen[want.kind]++;
        end
      end
      if (req_valid && req_stall === 1'b0) begin
        requests_taken++;
        if (req_item.dest == 5'd0) broadcasts_taken++;
        plan_route_commands(req_item);
        if (offer_row >= 0 && DIRECTED[offer_row].n_typed != 2'd0) begin
          // typed rows stand on their own; the plan above only keeps the copy in step
          board_commands_due.push_back(DIRECTED[offer_row].first_result);
          if (DIRECTED[offer_row].n_typed == 2'd2)
            board_commands_due.push_back(DIRECTED[offer_row].second_result);
        end else begin
          foreach (sweep_cmds[i]) board_commands_due.push_back(sweep_cmds[i]);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < N_DIRECTED; row++) send_request(DIRECTED[row].req, row);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_counts(PHASE_INPUTS[ph], PHASE_OUTPUTS[ph]);
      sender_gaps   = (ph != QUIET_PHASE);
      receiver_gaps = (ph != QUIET_PHASE);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) send_request(random_request(), -1);
      drain();
    end

    $display("run covered %0d requests (%0d broadcasts) over %0d count settings",
             requests_taken, broadcasts_taken, N_PHASES + 1);
    $display("%0d results: %0d connect, %0d disconnect, %0d done, %0d rejected; %0d bad",
             results_seen, kind_seen[xrc_pkg::KIND_CONNECT],
             kind_seen[xrc_pkg::KIND_DISCONNECT], kind_seen[xrc_pkg::KIND_DONE],
             kind_seen[xrc_pkg::KIND_REJECTED], mismatch_count);
    if (mismatch_count == 0 && board_commands_due.size() == 0) begin
      $display("[crosspoint_route_commander_core] OK");
    end else begin
      $display("[crosspoint_route_commander_core] ERROR");
    end
    $finish;
  end

  initial begin : run_limit
    #400_000;
    $display("timeout with %0d results still pending", board_commands_due.size());
    $display("[crosspoint_route_commander_core] ERROR");
    $finish;
  end

endmodule
